/* rtl/cts_pkg.sv */
// Shared types and codes of the cooperative task table scheduler.
package cts_pkg;

    // Request operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Result kind codes
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [23:0]        elapsed;
        logic [7:0]         task_id;
        logic signed [31:0] first_delay;
        logic [30:0]        repeat_period;
        logic [7:0]         slot;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] slot_index;
        logic [7:0] fired_id;
        logic       error;
        logic       last;
    } t_rsp;

    // One entry of the task table
    typedef struct packed {
        logic [7:0]         task_id;
        logic signed [31:0] delay;
        logic [30:0]        period;
    } t_slot;

endpackage

/* rtl/cts_req_if.sv */
// Request channel: valid/ready handshake carrying one scheduler request.
interface cts_req_if;
    logic          valid;
    logic          ready;
    cts_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/cts_rsp_if.sv */
// Response channel: valid/ready handshake carrying one scheduler result.
interface cts_rsp_if;
    logic          valid;
    logic          ready;
    cts_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/cooperative_task_table_scheduler_top.sv */
// Cooperative task table scheduler: microcoded sequencer over a slot memory.
//
//   channel   dir  handshake             payload
//   i_req     in   i_req.valid/ready     op, elapsed, task_id, first_delay,
//                                        repeat_period, slot
//   o_rsp     out  o_rsp.valid/ready     kind, slot_index, fired_id, error, last
//
// A tick runs TICK_RD, TICK_SCAN per slot and TICK_DONE; TICK_SCAN reads and
// updates one table slot per cycle while the output register is free. An add
// does a free-slot scan, two steps per slot; a delete runs the DEL step.
// Synchronous active-low reset empties the table at once (occupied bits clear).
// A step that can emit a result holds while the output register is still full.
module cooperative_task_table_scheduler_top #(
    parameter int TASK_SLOTS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cts_req_if.sink  i_req,
    cts_rsp_if.source o_rsp
);
    import cts_pkg::*;

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

    // Microprogram step addresses
    localparam logic [3:0] U_IDLE      = 4'd0;
    localparam logic [3:0] U_ADD_CHK   = 4'd1;
    localparam logic [3:0] U_ADD_SCAN  = 4'd2;
    localparam logic [3:0] U_ADD_TEST  = 4'd3;
    localparam logic [3:0] U_ADD_WR    = 4'd4;
    localparam logic [3:0] U_ADD_FULL  = 4'd5;
    localparam logic [3:0] U_ADD_BAD   = 4'd6;
    localparam logic [3:0] U_DEL       = 4'd7;
    localparam logic [3:0] U_TICK_RD   = 4'd8;
    localparam logic [3:0] U_TICK_SCAN = 4'd9;
    localparam logic [3:0] U_TICK_DONE = 4'd10;

    // Datapath functions
    localparam logic [2:0] F_NOP      = 3'd0;
    localparam logic [2:0] F_ACCEPT   = 3'd1;
    localparam logic [2:0] F_SCAN     = 3'd2;
    localparam logic [2:0] F_ADD_WR   = 3'd3;
    localparam logic [2:0] F_ADD_FULL = 3'd4;
    localparam logic [2:0] F_ADD_BAD  = 3'd5;
    localparam logic [2:0] F_DEL      = 3'd6;
    localparam logic [2:0] F_TICK     = 3'd7;

    // Jump conditions
    localparam logic [2:0] C_NEVER     = 3'd0;
    localparam logic [2:0] C_ALWAYS    = 3'd1;
    localparam logic [2:0] C_DISPATCH  = 3'd2;
    localparam logic [2:0] C_BAD_ID    = 3'd3;
    localparam logic [2:0] C_CNT_END   = 3'd4;
    localparam logic [2:0] C_SLOT_FREE = 3'd5;
    localparam logic [2:0] C_LAST_SLOT = 3'd6;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] cond;
        logic       emit;   // step may load the output register
        logic [3:0] next;
        logic [3:0] jump;
    } t_uop;

    // Control store
    function automatic t_uop ucode_rom(input logic [3:0] pc);
        t_uop u;
        u = '{func: F_NOP, cond: C_ALWAYS, emit: 1'b0, next: U_IDLE, jump: U_IDLE};
        unique case (pc)
            U_IDLE:      u = '{F_ACCEPT,   C_DISPATCH,  1'b0, U_IDLE,      U_IDLE};
            U_ADD_CHK:   u = '{F_NOP,      C_BAD_ID,    1'b0, U_ADD_SCAN,  U_ADD_BAD};
            U_ADD_SCAN:  u = '{F_NOP,      C_CNT_END,   1'b0, U_ADD_TEST,  U_ADD_FULL};
            U_ADD_TEST:  u = '{F_SCAN,     C_SLOT_FREE, 1'b0, U_ADD_SCAN,  U_ADD_WR};
            U_ADD_WR:    u = '{F_ADD_WR,   C_ALWAYS,    1'b1, U_IDLE,      U_IDLE};
            U_ADD_FULL:  u = '{F_ADD_FULL, C_ALWAYS,    1'b1, U_IDLE,      U_IDLE};
            U_ADD_BAD:   u = '{F_ADD_BAD,  C_ALWAYS,    1'b1, U_IDLE,      U_IDLE};
            U_DEL:       u = '{F_DEL,      C_ALWAYS,    1'b1, U_IDLE,      U_IDLE};
            U_TICK_RD:   u = '{F_NOP,      C_NEVER,     1'b0, U_TICK_SCAN, U_TICK_SCAN};
            U_TICK_SCAN: u = '{F_TICK,     C_LAST_SLOT, 1'b1, U_TICK_SCAN, U_TICK_DONE};
            U_TICK_DONE: u = '{F_NOP,      C_ALWAYS,    1'b1, U_IDLE,      U_IDLE};
            default:     u = '{F_NOP,      C_ALWAYS,    1'b0, U_IDLE,      U_IDLE};
        endcase
        return u;
    endfunction

    // Dispatch table on the request op
    function automatic logic [3:0] dispatch(input logic [1:0] op);
        logic [3:0] d;
        unique case (op)
            OP_TICK:   d = U_TICK_RD;
            OP_ADD:    d = U_ADD_CHK;
            OP_DELETE: d = U_DEL;
            OP_UNUSED: d = U_IDLE;
            default:   d = U_IDLE;
        endcase
        return d;
    endfunction

    logic [3:0]      r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [TASK_SLOTS-1:0] r_busy, n_busy;
    t_req            r_req;
    t_slot           r_rd;
    t_slot           mem [TASK_SLOTS];
    logic            r_out_valid, n_out_valid;
    t_rsp            r_out, n_out;

    t_uop            uop;
    logic            out_free;
    logic            hold;
    logic            accept;
    logic            cond_true;
    logic            mem_we;
    logic [SLOT_W-1:0] wr_addr, rd_addr;
    logic [CNT_W-1:0] cnt_inc;
    t_slot           wr_data;
    logic            cur_busy;
    logic            fire;
    logic            slot_ok;

    assign uop      = ucode_rom(r_pc);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign hold     = uop.emit && !out_free;
    assign accept   = (uop.func == F_ACCEPT) && i_req.valid;
    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign cur_busy = r_busy[r_cnt[SLOT_W-1:0]];
    assign fire     = cur_busy && (r_rd.delay <= 32'sd0);
    assign slot_ok  = r_req.slot < 8'(TASK_SLOTS);

    assign i_req.ready   = (uop.func == F_ACCEPT);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Jump condition select
    always_comb begin
        unique case (uop.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_DISPATCH:  cond_true = accept;
            C_BAD_ID:    cond_true = (r_req.task_id == 8'd0);
            C_CNT_END:   cond_true = (r_cnt == CNT_W'(TASK_SLOTS));
            C_SLOT_FREE: cond_true = !cur_busy;
            C_LAST_SLOT: cond_true = (r_cnt == CNT_W'(TASK_SLOTS - 1));
            default:     cond_true = 1'b0;
        endcase
    end

    // Sequencer and datapath
    always_comb begin
        n_pc        = r_pc;
        n_cnt       = r_cnt;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        wr_addr     = r_cnt[SLOT_W-1:0];
        wr_data     = r_rd;
        rd_addr     = r_cnt[SLOT_W-1:0];

        if (!hold) begin
            if (uop.cond == C_DISPATCH) begin
                n_pc = accept ? dispatch(i_req.payload.op) : U_IDLE;
            end else begin
                n_pc = cond_true ? uop.jump : uop.next;
            end

            unique case (uop.func)
                F_ACCEPT: begin
                    n_cnt = '0;
                end
                F_SCAN: begin
                    if (cur_busy) begin
                        n_cnt = cnt_inc;
                    end
                end
                F_ADD_WR: begin
                    mem_we                       = 1'b1;
                    wr_data.task_id              = r_req.task_id;
                    wr_data.delay                = r_req.first_delay;
                    wr_data.period               = r_req.repeat_period;
                    n_busy[r_cnt[SLOT_W-1:0]]    = 1'b1;
                    n_out_valid                  = 1'b1;
                    n_out = '{kind: KIND_ADD, slot_index: 4'(r_cnt), fired_id: 8'd0,
                              error: 1'b0, last: 1'b1};
                end
                F_ADD_FULL: begin
                    n_out_valid = 1'b1;
                    n_out = '{kind: KIND_ADD, slot_index: 4'(TASK_SLOTS), fired_id: 8'd0,
                              error: 1'b1, last: 1'b1};
                end
                F_ADD_BAD: begin
                    n_out_valid = 1'b1;
                    n_out = '{kind: KIND_ADD, slot_index: 4'd0, fired_id: 8'd0,
                              error: 1'b1, last: 1'b1};
                end
                F_DEL: begin
                    n_out_valid = 1'b1;
                    if (slot_ok) begin
                        n_busy[r_req.slot[SLOT_W-1:0]] = 1'b0;
                        n_out = '{kind: KIND_DELETE, slot_index: 4'(r_req.slot),
                                  fired_id: 8'd0, error: 1'b0, last: 1'b1};
                    end else begin
                        n_out = '{kind: KIND_DELETE, slot_index: 4'd0, fired_id: 8'd0,
                                  error: 1'b1, last: 1'b1};
                    end
                end
                F_TICK: begin
                    // Next slot read overlaps the write-back of this one.
                    rd_addr = cnt_inc[SLOT_W-1:0];
                    n_cnt   = cnt_inc;
                    // Results stay within int32: delay > 0 or period >= 0, less < 2^24.
                    if (fire) begin
                        n_out_valid = 1'b1;
                        n_out = '{kind: KIND_FIRE, slot_index: 4'(r_cnt),
                                  fired_id: r_rd.task_id, error: 1'b0, last: 1'b0};
                        if (r_rd.period == 31'd0) begin
                            n_busy[r_cnt[SLOT_W-1:0]] = 1'b0;
                        end else begin
                            mem_we        = 1'b1;
                            wr_data.delay = $signed({1'b0, r_rd.period})
                                          - $signed({8'd0, r_req.elapsed});
                        end
                    end else if (cur_busy) begin
                        mem_we        = 1'b1;
                        wr_data.delay = r_rd.delay - $signed({8'd0, r_req.elapsed});
                    end
                end
                F_NOP: begin
                    if (r_pc == U_TICK_DONE) begin
                        n_out_valid = 1'b1;
                        n_out = '{kind: KIND_DONE, slot_index: 4'd0, fired_id: 8'd0,
                                  error: 1'b0, last: 1'b1};
                    end
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= U_IDLE;
            r_cnt       <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_req <= i_req.payload;
        end
    end

    // Slot table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

endmodule
